[rtl/countdown_delay_slot_bank_unit_macros.svh]
// Assertion helpers shared by the block's modules.
// Each expects clk and rst_n in scope.
`ifndef COUNTDOWN_DELAY_SLOT_BANK_UNIT_MACROS_SVH
`define COUNTDOWN_DELAY_SLOT_BANK_UNIT_MACROS_SVH

// Same-cycle implication.
`define CDSB_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CDSB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cdsb_pkg.sv]
`timescale 1ns / 1ps

package cdsb_pkg;

    localparam int NUM_SLOTS_DEF   = 8;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int KIND_W   = 3;
    localparam int SLOT_W   = 3;
    localparam int DUR_W    = 32;
    localparam int STATUS_W = 2;
    localparam int PASSED_W = 16;

    localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NEW     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ADJUST  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RESTART = 3'd4;
    localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_USED = 2'd2;

    typedef struct packed {
        logic                latch;
        logic                addr_zero;
        logic                addr_slot;
        logic                addr_inc;
        logic                rd_en;
        logic                rd_next;
        logic                do_mod;
        logic                do_new;
        logic                do_remove;
        logic                set_status;
        logic [STATUS_W-1:0] status_val;
        logic                load_out;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              slot_ok;
        logic              slot_busy;
        logic              full;
        logic              addr_free;
        logic              addr_last;
    } sts_t;

endpackage

[rtl/countdown_delay_slot_bank_unit.sv]
`timescale 1ns / 1ps

// Bank of NUM_SLOTS countdown slots driven by a shared tick item; one result per item.
// Slot wait/counter pairs live in a single-port-write, registered-read memory; a tick walks
// it one slot per cycle with the next read overlapping the current write. The free-slot
// search for new steps through the in-use bits one per cycle. The next item is accepted
// while a result is still waiting on the output; no clearing pass after reset is needed.
module countdown_delay_slot_bank_unit #(
    parameter int NUM_SLOTS   = cdsb_pkg::NUM_SLOTS_DEF,
    parameter int COUNT_WIDTH = cdsb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [cdsb_pkg::KIND_W-1:0]   kind,
    input  logic [cdsb_pkg::SLOT_W-1:0]   slot,
    input  logic [cdsb_pkg::DUR_W-1:0]    duration_ms,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cdsb_pkg::STATUS_W-1:0] status,
    output logic [cdsb_pkg::SLOT_W-1:0]   granted_slot,
    output logic                          elapsed,
    output logic [cdsb_pkg::PASSED_W-1:0] ticks_passed,
    output logic                          running
);
    import cdsb_pkg::*;

    cmd_t cmd;
    sts_t sts;

    cdsb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    cdsb_datapath #(
        .NUM_SLOTS   (NUM_SLOTS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .kind         (kind),
        .slot         (slot),
        .duration_ms  (duration_ms),
        .status       (status),
        .granted_slot (granted_slot),
        .elapsed      (elapsed),
        .ticks_passed (ticks_passed),
        .running      (running)
    );

endmodule

[rtl/cdsb_datapath.sv]
`timescale 1ns / 1ps
`include "countdown_delay_slot_bank_unit_macros.svh"

module cdsb_datapath #(
    parameter int NUM_SLOTS   = cdsb_pkg::NUM_SLOTS_DEF,
    parameter int COUNT_WIDTH = cdsb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cdsb_pkg::cmd_t                cmd,
    output cdsb_pkg::sts_t                sts,
    input  logic [cdsb_pkg::KIND_W-1:0]   kind,
    input  logic [cdsb_pkg::SLOT_W-1:0]   slot,
    input  logic [cdsb_pkg::DUR_W-1:0]    duration_ms,
    output logic [cdsb_pkg::STATUS_W-1:0] status,
    output logic [cdsb_pkg::SLOT_W-1:0]   granted_slot,
    output logic                          elapsed,
    output logic [cdsb_pkg::PASSED_W-1:0] ticks_passed,
    output logic                          running
);
    import cdsb_pkg::*;

    localparam int CW   = COUNT_WIDTH;
    localparam int AW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNTW = $clog2(NUM_SLOTS + 1);
    localparam logic [AW-1:0]   LAST_ADDR = AW'(NUM_SLOTS - 1);
    localparam logic [CNTW-1:0] FULL_CNT  = CNTW'(NUM_SLOTS);

    logic [KIND_W-1:0] kind_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [CW-1:0]     dur_reg;
    logic [AW-1:0]     addr_reg;

    logic [NUM_SLOTS-1:0] in_use_reg;
    logic [NUM_SLOTS-1:0] elapsed_reg;
    logic [NUM_SLOTS-1:0] written_reg;
    logic [CNTW-1:0]      cnt_reg;

    logic [2*CW-1:0] mem [NUM_SLOTS];
    logic [2*CW-1:0] rd_data_reg;
    logic            rd_ok_reg;

    logic [STATUS_W-1:0] res_status_reg;
    logic [SLOT_W-1:0]   res_granted_reg;
    logic                res_el_reg;
    logic [PASSED_W-1:0] res_passed_reg;

    logic [STATUS_W-1:0] out_status_reg;
    logic [SLOT_W-1:0]   out_granted_reg;
    logic                out_el_reg;
    logic [PASSED_W-1:0] out_passed_reg;
    logic                out_running_reg;

    logic [AW-1:0]   slot_addr;
    logic [AW-1:0]   rd_addr;
    logic [CW-1:0]   entry_wait;
    logic [CW-1:0]   entry_cnt;
    logic [CW-1:0]   entry_diff;
    logic            wr_en;
    logic [2*CW-1:0] wr_data;
    logic            set_el;
    logic            clr_el;
    logic            take_query;

    assign slot_addr  = AW'(slot_reg);
    assign rd_addr    = cmd.rd_next ? (addr_reg + AW'(1)) : addr_reg;
    assign entry_wait = rd_ok_reg ? rd_data_reg[2*CW-1:CW] : '0;
    assign entry_cnt  = rd_ok_reg ? rd_data_reg[CW-1:0] : '0;
    assign entry_diff = entry_wait - entry_cnt;

    assign sts.kind      = kind_reg;
    assign sts.slot_ok   = (32'(slot_reg) < 32'(NUM_SLOTS));
    assign sts.slot_busy = in_use_reg[slot_addr];
    assign sts.full      = (cnt_reg >= FULL_CNT);
    assign sts.addr_free = !in_use_reg[addr_reg];
    assign sts.addr_last = (addr_reg == LAST_ADDR);

    always_comb
    begin
        wr_en      = 1'b0;
        wr_data    = {entry_wait, entry_cnt};
        set_el     = 1'b0;
        clr_el     = 1'b0;
        take_query = 1'b0;
        if (cmd.do_new)
        begin
            wr_en   = 1'b1;
            wr_data = {dur_reg, dur_reg};
        end
        else if (cmd.do_mod)
        begin
            case (kind_reg)
                KIND_TICK:
                begin
                    if (in_use_reg[addr_reg])
                    begin
                        if (entry_cnt != '0)
                        begin
                            wr_en   = 1'b1;
                            wr_data = {entry_wait, entry_cnt - CW'(1)};
                        end
                        else
                        begin
                            set_el = 1'b1;
                        end
                    end
                end
                KIND_ADJUST:
                begin
                    wr_en   = 1'b1;
                    wr_data = {dur_reg, entry_cnt};
                end
                KIND_RESTART:
                begin
                    wr_en   = 1'b1;
                    wr_data = {entry_wait, entry_wait};
                    clr_el  = (entry_wait != '0);
                end
                KIND_QUERY:
                begin
                    take_query = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr_reg] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg <= kind;
            slot_reg <= slot;
            dur_reg  <= CW'(duration_ms);
        end
        if (cmd.addr_zero)
        begin
            addr_reg <= '0;
        end
        else if (cmd.addr_slot)
        begin
            addr_reg <= slot_addr;
        end
        else if (cmd.addr_inc)
        begin
            addr_reg <= addr_reg + AW'(1);
        end
        if (cmd.rd_en)
        begin
            rd_ok_reg <= written_reg[rd_addr];
        end
        if (cmd.latch)
        begin
            res_status_reg  <= STATUS_OK;
            res_granted_reg <= '0;
            res_el_reg      <= 1'b0;
            res_passed_reg  <= '0;
        end
        else
        begin
            if (cmd.set_status)
            begin
                res_status_reg <= cmd.status_val;
            end
            if (cmd.do_new)
            begin
                res_granted_reg <= SLOT_W'(addr_reg);
            end
            if (take_query)
            begin
                res_el_reg     <= elapsed_reg[addr_reg];
                res_passed_reg <= PASSED_W'(entry_diff);
            end
        end
        if (cmd.load_out)
        begin
            out_status_reg  <= res_status_reg;
            out_granted_reg <= res_granted_reg;
            out_el_reg      <= res_el_reg;
            out_passed_reg  <= res_passed_reg;
            out_running_reg <= (cnt_reg != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg  <= '0;
            elapsed_reg <= '0;
            written_reg <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[addr_reg] <= 1'b1;
            end
            if (cmd.do_new)
            begin
                in_use_reg[addr_reg]  <= 1'b1;
                elapsed_reg[addr_reg] <= (dur_reg == '0);
                cnt_reg               <= cnt_reg + CNTW'(1);
            end
            else if (set_el)
            begin
                elapsed_reg[addr_reg] <= 1'b1;
            end
            else if (clr_el)
            begin
                elapsed_reg[addr_reg] <= 1'b0;
            end
            if (cmd.do_remove)
            begin
                in_use_reg[slot_addr] <= 1'b0;
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - CNTW'(1);
                end
            end
        end
    end

    assign status       = out_status_reg;
    assign granted_slot = out_granted_reg;
    assign elapsed      = out_el_reg;
    assign ticks_passed = out_passed_reg;
    assign running      = out_running_reg;

    `CDSB_ASSERT_IMPL(a_cnt_matches, 1'b1, 32'(cnt_reg) == $countones(in_use_reg), "slot count out of step with in-use bits")
    `CDSB_ASSERT_IMPL(a_new_free, cmd.do_new, !in_use_reg[addr_reg], "new claims a busy slot")
    `CDSB_ASSERT_IMPL(a_rd_next_range, cmd.rd_next, addr_reg != LAST_ADDR, "read ahead past last slot")

endmodule

[rtl/cdsb_ctrl.sv]
`timescale 1ns / 1ps
`include "countdown_delay_slot_bank_unit_macros.svh"

module cdsb_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  cdsb_pkg::sts_t sts,
    output cdsb_pkg::cmd_t cmd
);
    import cdsb_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_MOD    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.kind) inside
                    KIND_TICK:
                    begin
                        cmd.addr_zero = 1'b1;
                        state_next    = S_READ;
                    end
                    KIND_NEW:
                    begin
                        if (sts.full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status_val = STATUS_FULL;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            cmd.addr_zero = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end
                    KIND_REMOVE:
                    begin
                        if (!sts.slot_ok || !sts.slot_busy)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status_val = STATUS_NOT_USED;
                        end
                        else
                        begin
                            cmd.do_remove = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    KIND_ADJUST, KIND_RESTART, KIND_QUERY:
                    begin
                        if (!sts.slot_ok)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status_val = STATUS_NOT_USED;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            cmd.addr_slot = 1'b1;
                            state_next    = S_READ;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (sts.addr_free)
                begin
                    cmd.do_new = 1'b1;
                    state_next = S_DONE;
                end
                else if (sts.addr_last)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = STATUS_FULL;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.addr_inc = 1'b1;
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                cmd.do_mod = 1'b1;
                if ((sts.kind == KIND_TICK) && !sts.addr_last)
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_next  = 1'b1;
                    cmd.addr_inc = 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `CDSB_ASSERT_IMPL(a_load_free, cmd.load_out, !out_valid_reg || !out_stall, "result overwritten while stalled")
    `CDSB_ASSERT_NEXT(a_accept_decode, in_valid && !in_stall, state_reg == S_DECODE, "accepted item not decoded")
    `CDSB_ASSERT_NEXT(a_single_mod, (state_reg == S_MOD) && (sts.kind != KIND_TICK), state_reg == S_DONE, "single-slot op did not finish")

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import cdsb_pkg::*;

    localparam int NSLOT = NUM_SLOTS_DEF;
    localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;
    localparam int RANDOM_ITEMS = 1200;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   granted;
        logic                elapsed;
        logic [PASSED_W-1:0] passed;
        logic                running;
    } result_t;

    class slot_bank_scoreboard;
        bit              in_use[NSLOT];
        bit [DUR_W-1:0]  reload_val[NSLOT];
        bit [DUR_W-1:0]  counter[NSLOT];
        bit              elapsed_flag[NSLOT];
        int unsigned     busy_total;
        result_t         pending_q[$];
        int              errors;

        function void note(logic [KIND_W-1:0] k, logic [SLOT_W-1:0] s, logic [DUR_W-1:0] d);
            result_t        r;
            int             free_idx;
            bit             ok;
            bit [DUR_W-1:0] diff;
            r = '0;
            ok = int'(s) < NSLOT;
            case (k)
                KIND_TICK:
                    for (int i = 0; i < NSLOT; i++)
                    begin
                        if (in_use[i])
                        begin
                            if (counter[i] != 0)
                                counter[i] = counter[i] - 1;
                            else
                                elapsed_flag[i] = 1'b1;
                        end
                    end
                KIND_NEW:
                begin
                    free_idx = -1;
                    for (int i = NSLOT - 1; i >= 0; i--)
                        if (!in_use[i])
                            free_idx = i;
                    if (busy_total >= NSLOT || free_idx < 0)
                        r.status = STATUS_FULL;
                    else
                    begin
                        in_use[free_idx] = 1'b1;
                        reload_val[free_idx] = d;
                        counter[free_idx] = d;
                        elapsed_flag[free_idx] = (d == 0);
                        busy_total++;
                        r.granted = free_idx[SLOT_W-1:0];
                    end
                end
                KIND_ADJUST:
                    if (!ok)
                        r.status = STATUS_NOT_USED;
                    else
                        reload_val[s] = d;
                KIND_REMOVE:
                    if (!ok || !in_use[s])
                        r.status = STATUS_NOT_USED;
                    else
                    begin
                        in_use[s] = 1'b0;
                        if (busy_total > 0)
                            busy_total--;
                    end
                KIND_RESTART:
                    if (!ok)
                        r.status = STATUS_NOT_USED;
                    else
                    begin
                        counter[s] = reload_val[s];
                        if (reload_val[s] != 0)
                            elapsed_flag[s] = 1'b0;
                    end
                KIND_QUERY:
                    if (!ok)
                        r.status = STATUS_NOT_USED;
                    else
                    begin
                        diff = reload_val[s] - counter[s];
                        r.elapsed = elapsed_flag[s];
                        r.passed = diff[PASSED_W-1:0];
                    end
                default: ;
            endcase
            r.running = busy_total != 0;
            pending_q.push_back(r);
        endfunction

        function void check(result_t got);
            result_t want;
            if (pending_q.size() == 0)
            begin
                $error("result with no item pending");
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.granted !== want.granted)
            begin
                $error("granted_slot: expected %0d, got %0d", want.granted, got.granted);
                errors++;
            end
            if (got.elapsed !== want.elapsed)
            begin
                $error("elapsed: expected %0d, got %0d", want.elapsed, got.elapsed);
                errors++;
            end
            if (got.passed !== want.passed)
            begin
                $error("ticks_passed: expected %0d, got %0d", want.passed, got.passed);
                errors++;
            end
            if (got.running !== want.running)
            begin
                $error("running: expected %0d, got %0d", want.running, got.running);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [KIND_W-1:0]   kind;
    logic [SLOT_W-1:0]   slot;
    logic [DUR_W-1:0]    duration_ms;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   granted_slot;
    logic                elapsed;
    logic [PASSED_W-1:0] ticks_passed;
    logic                running;

    slot_bank_scoreboard sb;
    bit                  quiet;

    countdown_delay_slot_bank_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .slot         (slot),
        .duration_ms  (duration_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .granted_slot (granted_slot),
        .elapsed      (elapsed),
        .ticks_passed (ticks_passed),
        .running      (running)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= !quiet && ($urandom_range(99) < 24);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check('{status, granted_slot, elapsed, ticks_passed, running});
            if (in_valid && !in_stall)
                sb.note(kind, slot, duration_ms);
        end
    end

    task automatic issue_item(logic [KIND_W-1:0] k, logic [SLOT_W-1:0] s, logic [DUR_W-1:0] d);
        while (!quiet && $urandom_range(99) < 24)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        kind        <= k;
        slot        <= s;
        duration_ms <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [DUR_W-1:0] pick_duration();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return $urandom_range(15);
        else if (roll < 85)
            return $urandom_range(16'hFFFF);
        return $urandom;
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 35)
            return KIND_TICK;
        else if (roll < 50)
            return KIND_NEW;
        else if (roll < 58)
            return KIND_ADJUST;
        else if (roll < 70)
            return KIND_REMOVE;
        else if (roll < 80)
            return KIND_RESTART;
        else if (roll < 98)
            return KIND_QUERY;
        return $urandom_range(1) ? KIND_SPARE6 : KIND_SPARE7;
    endfunction

    initial
    begin
        int               n;
        logic [KIND_W-1:0] k;
        sb = new();
        quiet = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = KIND_TICK;
        slot = '0;
        duration_ms = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        issue_item(KIND_QUERY, 3'd0, 32'd0);
        issue_item(KIND_TICK, 3'd0, 32'd0);
        issue_item(KIND_NEW, 3'd0, 32'd0);
        issue_item(KIND_NEW, 3'd7, 32'hFFFF_FFFF);
        issue_item(KIND_NEW, 3'd0, 32'd3);
        issue_item(KIND_NEW, 3'd0, 32'd1);
        issue_item(KIND_NEW, 3'd0, 32'd2);
        issue_item(KIND_NEW, 3'd0, 32'h8000_0000);
        issue_item(KIND_NEW, 3'd0, 32'd5);
        issue_item(KIND_NEW, 3'd0, 32'h0001_0000);
        issue_item(KIND_NEW, 3'd0, 32'd9);
        issue_item(KIND_TICK, 3'd0, 32'd0);
        issue_item(KIND_QUERY, 3'd1, 32'd0);
        issue_item(KIND_QUERY, 3'd7, 32'd0);
        issue_item(KIND_REMOVE, 3'd3, 32'd0);
        issue_item(KIND_REMOVE, 3'd3, 32'd0);
        issue_item(KIND_ADJUST, 3'd3, 32'd0);
        issue_item(KIND_RESTART, 3'd3, 32'd0);
        issue_item(KIND_QUERY, 3'd3, 32'd0);
        issue_item(KIND_ADJUST, 3'd2, 32'hFFFF_FFFF);
        issue_item(KIND_RESTART, 3'd2, 32'd0);
        issue_item(KIND_QUERY, 3'd2, 32'd0);
        issue_item(KIND_SPARE6, 3'd5, 32'd0);
        issue_item(KIND_SPARE7, 3'd2, 32'hFFFF_FFFF);
        issue_item(KIND_NEW, 3'd0, 32'd4);
        drain_results();

        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            quiet = (n >= 300 && n < 500);
            if (n == 700)
                drain_results();
            k = pick_kind();
            issue_item(k, SLOT_W'($urandom_range(NSLOT - 1)), pick_duration());
            if (k != KIND_SPARE6 && k != KIND_SPARE7)
                n++;
        end
        quiet = 1'b0;

        drain_results();
        repeat (40) @(posedge clk);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/cdsb_pkg.sv
rtl/cdsb_datapath.sv
rtl/cdsb_ctrl.sv
rtl/countdown_delay_slot_bank_unit.sv
tb/tb.sv
